[rtl/core/button_click_classifier_macros.svh]
// Assertion macros for the button click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/bcc_pkg.sv]
`default_nettype none

package bcc_pkg;

    localparam int unsigned PHASE_W = 3;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // press phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PRESSED  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LONG     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SECOND   = 3'd5;

    // click events
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL = 2'd2;

    // register reset values
    localparam logic [COUNT_W-1:0] LONG_TICKS_RST  = 8'd50;
    localparam logic [COUNT_W-1:0] DOUBLE_WAIT_RST = 8'd25;
    localparam logic               PRESS_LEVEL_RST = 1'b0;

    typedef struct packed {
        logic [COUNT_W-1:0] long_press_ticks;
        logic [COUNT_W-1:0] double_wait_ticks;
        logic               pressed_level;
    } t_cfg;

endpackage

`default_nettype wire

[rtl/core/bcc_cfg.sv]
`default_nettype none

module bcc_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bcc_pkg::t_cfg                       o_cfg
);
    import bcc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LONG_TICKS:  n_cfg.long_press_ticks  = i_cfg_data[COUNT_W-1:0];
                CFG_DOUBLE_WAIT: n_cfg.double_wait_ticks = i_cfg_data[COUNT_W-1:0];
                CFG_PRESS_LEVEL: n_cfg.pressed_level     = i_cfg_data[0];
                default:         n_cfg = r_cfg;  // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks  <= LONG_TICKS_RST;
            r_cfg.double_wait_ticks <= DOUBLE_WAIT_RST;
            r_cfg.pressed_level     <= PRESS_LEVEL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/core/bcc_fsm.sv]
`default_nettype none
`include "button_click_classifier_macros.svh"

module bcc_fsm (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_pin_level,
    input  wire bcc_pkg::t_cfg               i_cfg,
    output logic [bcc_pkg::EVENT_W-1:0]      o_event
);
    import bcc_pkg::*;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [EVENT_W-1:0] n_event;
    logic               held;
    logic               long_hit;
    logic               wait_hit;
    logic [COUNT_W-1:0] count_inc;

    assign held      = (i_pin_level == i_cfg.pressed_level);
    assign long_hit  = (r_count >= i_cfg.long_press_ticks);
    assign wait_hit  = (r_count >= i_cfg.double_wait_ticks);
    assign count_inc = r_count + COUNT_W'(1);  // only taken below a limit, no wrap

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_event = EV_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                n_phase = held ? PH_DEBOUNCE : PH_IDLE;
            end
            PH_DEBOUNCE: begin
                n_phase = held ? PH_PRESSED : PH_IDLE;
            end
            PH_PRESSED: begin
                if (held && long_hit) begin
                    n_phase = PH_LONG;
                    n_count = '0;
                end else if (held) begin
                    n_count = count_inc;
                end else begin
                    n_phase = PH_WAIT;
                    n_count = '0;
                end
            end
            PH_LONG: begin
                n_count = '0;
                if (!held) begin
                    n_phase = PH_IDLE;
                    n_event = EV_LONG;
                end
            end
            PH_WAIT: begin
                if (!held && wait_hit) begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                    n_event = EV_SINGLE;
                end else if (!held) begin
                    n_count = count_inc;
                end else begin
                    n_phase = PH_SECOND;
                    n_count = '0;
                end
            end
            PH_SECOND: begin
                // held to the long limit: single click now, long press on release
                if (held && long_hit) begin
                    n_phase = PH_LONG;
                    n_count = '0;
                    n_event = EV_SINGLE;
                end else if (held) begin
                    n_count = count_inc;
                end else begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                    n_event = EV_DOUBLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_event = n_event;

    `BCC_ASSERT_NOW(a_count_clear_idle, i_clk, i_rst_n,
        (r_phase == PH_IDLE) || (r_phase == PH_DEBOUNCE) || (r_phase == PH_LONG),
        r_count == '0)
    `BCC_ASSERT_NEXT(a_hold_when_stalled, i_clk, i_rst_n, !i_step,
        $stable(r_phase) && $stable(r_count))
    `BCC_ASSERT_NOW(a_long_only_from_long, i_clk, i_rst_n, n_event == EV_LONG,
        r_phase == PH_LONG)

endmodule

`default_nettype wire

[rtl/core/button_click_classifier.sv]
// Button click classifier: one pin sample in, one click event out per item.
// Path: an accepted sample waits in the input register, then its event goes to the result register.
// Throughput: 1 item per cycle while the output is not stalled; phase/counter update is combinational.
// Reset: synchronous active-low i_rst_n clears phase, counter and both valid flags,
// and loads the registers with long 50, double wait 25, pressed level 0.
`default_nettype none
`include "button_click_classifier_macros.svh"

module button_click_classifier (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config write port
    input  wire logic                           i_cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_pin_level,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [bcc_pkg::EVENT_W-1:0]         o_click_event
);
    import bcc_pkg::*;

    t_cfg               cfg;
    logic [EVENT_W-1:0] step_event;

    // input register
    logic r_in_valid;
    logic r_in_pin;
    // result register
    logic               r_out_valid;
    logic [EVENT_W-1:0] r_out_event;

    logic in_take;
    logic advance;

    // an item moves from input to result register when the result slot is
    // empty or being taken this cycle; the FSM steps on the same edge
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    bcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bcc_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_pin_level (r_in_pin),
        .i_cfg       (cfg),
        .o_event     (step_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pin <= i_pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= step_event;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_click_event = r_out_event;

    `BCC_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid)
    `BCC_ASSERT_NEXT(a_blocked_item_kept, i_clk, i_rst_n, o_in_stall,
        r_in_valid && $stable(r_in_pin))
    `BCC_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall,
        r_in_valid && r_out_valid && i_out_stall)

endmodule

`default_nettype wire

[verif/tb_button_click_classifier.sv]
`timescale 1ns / 100ps

module tb_button_click_classifier;
    import bcc_pkg::*;

    // Clock and run bounds
    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_LIMIT   = 4000;
    // result path is two registers deep; settle a few cycles past that
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned DIR_ROWS      = 28;
    localparam int unsigned N_PHASES      = 6;

    // Index past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Directed rows: either the expected click is typed in, or the predictor decides
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef struct packed {
        logic               pin;
        logic               typed;
        logic [EVENT_W-1:0] click;
    } t_dir_row;

    // Random phases: register settings plus idle mix
    typedef struct {
        int   long_ticks;
        int   wait_ticks;
        logic level;
        int   items;
        int   hold_tail;
        int   sender_pct;
        int   recv_pct;
    } t_phase_plan;

    typedef enum int {
        SEQ_SINGLE,
        SEQ_DOUBLE,
        SEQ_LONG,
        SEQ_SECOND_LONG,
        SEQ_NOISE
    } t_press_seq;

    // DUT hookup
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_LONG_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  pin_level   = 1'b0;
    logic                  out_stall   = 1'b0;
    wire logic             in_stall;
    wire logic             out_valid;
    wire logic [EVENT_W-1:0] click_event;

    // Predictor state, mirrored registers and scoreboard
    logic [PHASE_W-1:0]    model_phase = PH_IDLE;
    logic [COUNT_W-1:0]    model_count = '0;
    logic [COUNT_W-1:0]    model_long  = LONG_TICKS_RST;
    logic [COUNT_W-1:0]    model_wait  = DOUBLE_WAIT_RST;
    logic                  model_level = PRESS_LEVEL_RST;
    logic [EVENT_W-1:0]    expected_clicks [$];
    logic                  pin_script [$];

    int unsigned           sender_pct  = 28;
    int unsigned           recv_pct    = 65;
    int unsigned           error_count = 0;
    int unsigned           result_count = 0;
    int unsigned           cycle_count = 0;

    // Directed walk under long = 2, wait = 2, pressed level 0.
    // Covers single, double, long, second press held long, and a debounce glitch.
    t_dir_row directed_rows [DIR_ROWS] = '{
        // released in idle: nothing happens
        '{1'b1, TYPED, EV_NONE},
        // single click: press, release, wait out the double window
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b1, PRED,  EV_NONE},
        '{1'b1, PRED,  EV_NONE},
        '{1'b1, PRED,  EV_NONE},
        '{1'b1, TYPED, EV_SINGLE},
        // double click
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b1, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b1, TYPED, EV_DOUBLE},
        // long press, reported on release
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b1, TYPED, EV_LONG},
        // second press held past the limit: single now, long on release
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b1, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, PRED,  EV_NONE},
        '{1'b0, TYPED, EV_SINGLE},
        '{1'b1, TYPED, EV_LONG},
        // one-tick glitch falls back out of debounce
        '{1'b0, PRED,  EV_NONE},
        '{1'b1, PRED,  EV_NONE}
    };

    // Phase 1 ends on a long hold at limit 255 so phase 2 (limit 1) sees a
    // counter already past the new limit. Phase 3 uses zero limits.
    t_phase_plan phase_plan [N_PHASES] = '{
        '{4,   3,   1'b1, 300, 0,  28, 65},
        '{255, 255, 1'b0, 400, 40, 28, 65},
        '{1,   1,   1'b0, 250, 0,  65, 28},
        '{0,   0,   1'b1, 150, 0,  65, 28},
        '{8,   5,   1'b0, 200, 0,  0,  0},
        '{12,  20,  1'b1, 150, 0,  0,  0}
    };

    button_click_classifier u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_pin_level   (pin_level),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_click_event (click_event)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Hard stop if the run hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit roll(input int unsigned pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // One tick of the classifier; advances the mirrored phase and counter
    function automatic logic [EVENT_W-1:0] classify_tick(input logic pin);
        logic               held;
        logic [EVENT_W-1:0] click;
        held  = (pin == model_level);
        click = EV_NONE;
        case (model_phase)
            PH_IDLE: begin
                model_phase = held ? PH_DEBOUNCE : PH_IDLE;
            end
            PH_DEBOUNCE: begin
                model_phase = held ? PH_PRESSED : PH_IDLE;
            end
            PH_PRESSED: begin
                if (held && model_count >= model_long) begin
                    model_phase = PH_LONG;
                    model_count = '0;
                end else if (held) begin
                    model_count = model_count + 1'b1;
                end else begin
                    model_phase = PH_WAIT;
                    model_count = '0;
                end
            end
            PH_LONG: begin
                model_count = '0;
                if (!held) begin
                    model_phase = PH_IDLE;
                    click       = EV_LONG;
                end
            end
            PH_WAIT: begin
                if (!held && model_count >= model_wait) begin
                    model_phase = PH_IDLE;
                    model_count = '0;
                    click       = EV_SINGLE;
                end else if (!held) begin
                    model_count = model_count + 1'b1;
                end else begin
                    model_phase = PH_SECOND;
                    model_count = '0;
                end
            end
            PH_SECOND: begin
                if (held && model_count >= model_long) begin
                    model_phase = PH_LONG;
                    model_count = '0;
                    click       = EV_SINGLE;
                end else if (held) begin
                    model_count = model_count + 1'b1;
                end else begin
                    model_phase = PH_IDLE;
                    model_count = '0;
                    click       = EV_DOUBLE;
                end
            end
            default: begin
                // unused phase codes recover to idle
                model_phase = PH_IDLE;
                model_count = '0;
            end
        endcase
        return click;
    endfunction

    // Register write; mirror updates at the write edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_LONG_TICKS:  model_long  = data;
            CFG_DOUBLE_WAIT: model_wait  = data;
            CFG_PRESS_LEVEL: model_level = data[0];
            default: ;
        endcase
    endtask

    // Only while idle: drain, settle, then write all registers plus the unused index
    task automatic apply_config(input int long_t, input int wait_t, input logic level);
        logic [CFG_DATA_W-1:0] level_word;
        logic [CFG_DATA_W-1:0] junk_word;
        in_valid <= 1'b0;
        while (expected_clicks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        // upper bits of the level word are don't-care
        level_word    = CFG_DATA_W'($urandom);
        level_word[0] = level;
        junk_word     = CFG_DATA_W'($urandom);
        write_reg(CFG_LONG_TICKS, long_t[CFG_DATA_W-1:0]);
        write_reg(CFG_DOUBLE_WAIT, wait_t[CFG_DATA_W-1:0]);
        write_reg(CFG_PRESS_LEVEL, level_word);
        write_reg(CFG_UNUSED, junk_word);
        cfg_we <= 1'b0;
    endtask

    // Send one pin sample; valid stays high into the next item unless a gap is rolled
    task automatic push_pin(input logic pin, input logic typed,
                            input logic [EVENT_W-1:0] typed_click);
        logic [EVENT_W-1:0] predicted;
        while (roll(sender_pct)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        do @(posedge clk); while (in_stall);
        predicted = classify_tick(pin);
        expected_clicks.push_back(typed ? typed_click : predicted);
    endtask

    task automatic add_ticks(input logic level, input int n);
        repeat (n) pin_script.push_back(level);
    endtask

    // Mostly well-formed press patterns with durations around the current limits
    task automatic build_script(input int items, input int long_t, input int wait_t,
                                input logic level, input int hold_tail);
        t_press_seq kind;
        int         pick;
        pin_script.delete();
        while (pin_script.size() < items) begin
            pick = $urandom_range(9, 0);
            kind = (pick < 3) ? SEQ_SINGLE :
                   (pick < 5) ? SEQ_DOUBLE :
                   (pick < 7) ? SEQ_LONG :
                   (pick < 9) ? SEQ_SECOND_LONG : SEQ_NOISE;
            case (kind)
                SEQ_SINGLE: begin
                    add_ticks(level, $urandom_range(long_t + 1, 1));
                    add_ticks(!level, $urandom_range(wait_t + 4, 1));
                end
                SEQ_DOUBLE: begin
                    add_ticks(level, $urandom_range(4, 2));
                    add_ticks(!level, $urandom_range(wait_t + 1, 1));
                    add_ticks(level, $urandom_range(long_t + 1, 1));
                    add_ticks(!level, $urandom_range(wait_t + 5, wait_t + 2));
                end
                SEQ_LONG: begin
                    add_ticks(level, $urandom_range(long_t + 8, long_t + 3));
                    add_ticks(!level, $urandom_range(wait_t + 4, 1));
                end
                SEQ_SECOND_LONG: begin
                    add_ticks(level, $urandom_range(4, 2));
                    add_ticks(!level, $urandom_range(wait_t + 1, 1));
                    add_ticks(level, $urandom_range(long_t + 6, long_t + 2));
                    add_ticks(!level, $urandom_range(4, 1));
                end
                default: begin
                    repeat ($urandom_range(8, 1)) pin_script.push_back(1'($urandom_range(1, 0)));
                end
            endcase
        end
        // phase may end mid-press; the next phase picks up from there
        while (pin_script.size() > items) void'(pin_script.pop_back());
        add_ticks(level, hold_tail);
    endtask

    // Receiver stall, re-rolled every cycle
    always @(posedge clk) begin
        out_stall <= roll(recv_pct);
    end

    // Scoreboard: every accepted result against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            result_count++;
            if (expected_clicks.size() == 0) begin
                report_mismatch($sformatf("click %0d with nothing expected", click_event));
            end else begin
                if (click_event !== expected_clicks[0]) begin
                    report_mismatch($sformatf("result %0d click %0d, expected %0d",
                                              result_count, click_event, expected_clicks[0]));
                end
                void'(expected_clicks.pop_front());
            end
        end
    end

    initial begin : stimulus
        int unsigned drain_wait;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk, sender/receiver idling in the first mix
        sender_pct = 28;
        recv_pct   = 65;
        apply_config(2, 2, 1'b0);
        for (int r = 0; r < DIR_ROWS; r++) begin
            push_pin(directed_rows[r].pin, directed_rows[r].typed, directed_rows[r].click);
        end

        // Random phases
        for (int p = 0; p < N_PHASES; p++) begin
            apply_config(phase_plan[p].long_ticks, phase_plan[p].wait_ticks,
                         phase_plan[p].level);
            sender_pct = phase_plan[p].sender_pct;
            recv_pct   = phase_plan[p].recv_pct;
            build_script(phase_plan[p].items, phase_plan[p].long_ticks,
                         phase_plan[p].wait_ticks, phase_plan[p].level,
                         phase_plan[p].hold_tail);
            for (int i = 0; i < pin_script.size(); i++) begin
                if (i == pin_script.size() / 2) begin
                    // hold the sender until the block has fully drained
                    in_valid <= 1'b0;
                    do @(posedge clk); while (expected_clicks.size() != 0);
                end
                push_pin(pin_script[i], PRED, EV_NONE);
            end
        end

        // Drain and settle
        in_valid <= 1'b0;
        drain_wait = 0;
        while (expected_clicks.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_clicks.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_clicks.size()));
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
